### rtl/assert_macros.svh
// Assertion macros used by the receiver RTL (the fsr_ctrl sequencer).
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/fsr_pkg.sv
// Shared types, constants and the CRC-16 byte step for the frame receiver.
// No dependencies.
`default_nettype none
package fsr_pkg;

  localparam int FRAME_DEPTH = 64;
  localparam int ADDR_W      = $clog2(FRAME_DEPTH);
  localparam int LEN_MAX     = (FRAME_DEPTH < 64) ? FRAME_DEPTH : 64;
  localparam int POS_W       = 7;

  localparam logic [POS_W-1:0] LEN_MIN_L = 7'd9;
  localparam logic [POS_W-1:0] LEN_MAX_L = POS_W'(LEN_MAX);
  localparam logic [POS_W-1:0] QUERY_LEN = 7'd8;
  localparam int BYTE_COUNT_POS = 6;
  localparam int PAYLOAD_START  = 7;

  localparam logic [7:0]  FC_QUERY = 8'h03;
  localparam logic [7:0]  FC_WRITE = 8'h10;
  localparam logic [7:0]  FC_TEST  = 8'hAD;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] CFG_GAP_TICKS  = 2'd1;
  localparam logic [1:0] CFG_LONG_LEN   = 2'd2;

  localparam logic [7:0] SLAVE_ADDR_RST = 8'd0;
  localparam logic [9:0] GAP_TICKS_RST  = 10'd50;
  localparam logic [6:0] LONG_LEN_RST   = 7'd53;

  typedef enum logic [2:0] {
    ST_QUERY_OK = 3'd0,
    ST_WRITE_OK = 3'd1,
    ST_CRC_ERR  = 3'd2,
    ST_BAD_LEN  = 3'd3,
    ST_UNKNOWN  = 3'd4,
    ST_TEST     = 3'd5,
    ST_TIMEOUT  = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0] slave_address;
    logic [9:0] gap_timeout_ticks;
    logic [6:0] long_frame_bytes;
  } cfg_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] function_code;
    logic [5:0] data_index;
    logic [7:0] data_byte;
    logic       last;
  } res_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

endpackage
`default_nettype wire

### rtl/fsr_frame_ram.sv
// Frame byte store: one write port, one registered read port.
// Depends on fsr_pkg.
`default_nettype none
module fsr_frame_ram (
  input  wire logic                      clk,
  input  wire fsr_pkg::ram_wr_t          wr,
  input  wire logic [fsr_pkg::ADDR_W-1:0] raddr,
  output logic [7:0]                     rdata
);
  import fsr_pkg::*;

  logic [7:0] mem [FRAME_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/fsr_out_reg.sv
// Output register for result transfers; packs results onto the master stream.
// Depends on fsr_pkg.
`default_nettype none
module fsr_out_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire fsr_pkg::res_t in_res,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [31:0]        m_axis_tdata,  // status[2:0], function_code[10:3],
                                            // data_index[16:11], data_byte[24:17]
  output logic               m_axis_tlast
);
  import fsr_pkg::*;

  logic full;

  assign in_ready      = !full || m_axis_tready;
  assign m_axis_tvalid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      m_axis_tdata <= {7'b0, in_res.data_byte, in_res.data_index,
                       in_res.function_code, in_res.status};
      m_axis_tlast <= in_res.last;
    end
  end

endmodule
`default_nettype wire

### rtl/fsr_ctrl.sv
// Frame sequencer: stores bytes, tracks CRC and gap, checks write frames
// by rereading the frame store, and walks payload bytes. Depends on fsr_pkg.
`default_nettype none
`include "assert_macros.svh"
module fsr_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire fsr_pkg::cfg_t              cfg,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_kind,
  input  wire logic [7:0]                 in_byte,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output fsr_pkg::res_t                   res,
  output fsr_pkg::ram_wr_t                ram_wr,
  output logic [fsr_pkg::ADDR_W-1:0]      ram_raddr,
  input  wire logic [7:0]                 ram_rdata
);
  import fsr_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_EMIT    = 8'b0000_0010,
    S_LEN     = 8'b0000_0100,
    S_CRC     = 8'b0000_1000,
    S_CKLO    = 8'b0001_0000,
    S_CKHI    = 8'b0010_0000,
    S_RUN     = 8'b0100_0000,
    S_RUNEMIT = 8'b1000_0000
  } state_t;

  state_t           state, state_next;
  logic             receiving, receiving_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [9:0]       gap, gap_next;
  logic [15:0]      crc, crc_next;
  logic [7:0]       fc, fc_next;
  logic [5:0]       idx, idx_next;
  logic [5:0]       n_last, n_last_next;
  logic [15:0]      crc_chk, crc_chk_next;
  logic             lo_ok, lo_ok_next;
  res_t             pend, pend_next;

  logic [POS_W-1:0] frame_len;
  logic [9:0]       limit;
  logic [15:0]      crc_upd;
  logic [15:0]      crc_run;
  logic [POS_W-1:0] pos_inc;
  logic [9:0]       gap_inc;
  logic [7:0]       code;
  logic [8:0]       n_full;
  logic             too_long;
  logic [POS_W-1:0] idx_ext;
  logic             end_now;

  function automatic res_t status_res(input status_t st, input logic [7:0] f);
    res_t r;
    r.status        = st;
    r.function_code = f;
    r.data_index    = '0;
    r.data_byte     = '0;
    r.last          = 1'b1;
    return r;
  endfunction

  always_comb begin
    if (cfg.long_frame_bytes < LEN_MIN_L) begin
      frame_len = LEN_MIN_L;
    end else if (cfg.long_frame_bytes > LEN_MAX_L) begin
      frame_len = LEN_MAX_L;
    end else begin
      frame_len = cfg.long_frame_bytes;
    end
  end

  assign limit    = (cfg.gap_timeout_ticks == '0) ? 10'd1 : cfg.gap_timeout_ticks;
  assign crc_upd  = crc16_byte(receiving ? crc : CRC_INIT, in_byte);
  assign crc_run  = crc16_byte(crc_chk, ram_rdata);
  assign pos_inc  = pos + 7'd1;
  assign gap_inc  = (gap != 10'h3FF) ? gap + 10'd1 : gap;
  assign code     = (pos == 7'd1) ? in_byte : fc;
  assign n_full   = {1'b0, ram_rdata} + 9'(PAYLOAD_START);
  assign too_long = (n_full + 9'd2) > {2'b0, frame_len};
  assign idx_ext  = {1'b0, idx};

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_EMIT) || (state == S_RUNEMIT);
  assign res       = pend;

  always_comb begin
    case (state)
      S_IDLE:                    ram_raddr = ADDR_W'(BYTE_COUNT_POS);
      S_CRC, S_CKLO, S_RUNEMIT:  ram_raddr = ADDR_W'(idx + 6'd1);
      S_CKHI:                    ram_raddr = ADDR_W'(PAYLOAD_START);
      default:                   ram_raddr = '0;
    endcase
  end

  always_comb begin
    state_next     = state;
    receiving_next = receiving;
    pos_next       = pos;
    gap_next       = gap;
    crc_next       = crc;
    fc_next        = fc;
    idx_next       = idx;
    n_last_next    = n_last;
    crc_chk_next   = crc_chk;
    lo_ok_next     = lo_ok;
    pend_next      = pend;
    end_now        = 1'b0;
    ram_wr         = '0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_TICK) begin
            if (receiving) begin
              gap_next = gap_inc;
              if (gap_inc >= limit) begin
                pend_next  = status_res(ST_TIMEOUT, (pos >= 7'd2) ? fc : 8'h00);
                end_now    = 1'b1;
                state_next = S_EMIT;
              end
            end
          end else begin
            gap_next = '0;
            if (!receiving) begin
              if (in_byte == cfg.slave_address) begin
                receiving_next = 1'b1;
                ram_wr.en      = 1'b1;
                ram_wr.addr    = '0;
                ram_wr.data    = in_byte;
                pos_next       = 7'd1;
                crc_next       = crc_upd;
              end
            end else begin
              ram_wr.en   = 1'b1;
              ram_wr.addr = ADDR_W'(pos);
              ram_wr.data = in_byte;
              pos_next    = pos_inc;
              crc_next    = crc_upd;
              if (pos == 7'd1) begin
                fc_next = in_byte;
              end
              if (code == FC_QUERY) begin
                if (pos_inc >= QUERY_LEN) begin
                  pend_next  = status_res((crc_upd == '0) ? ST_QUERY_OK : ST_CRC_ERR, code);
                  end_now    = 1'b1;
                  state_next = S_EMIT;
                end
              end else if (code == FC_TEST) begin
                pend_next  = status_res(ST_TEST, code);
                end_now    = 1'b1;
                state_next = S_EMIT;
              end else if (pos_inc >= frame_len) begin
                end_now = 1'b1;
                if (code == FC_WRITE) begin
                  state_next = S_LEN;
                end else begin
                  pend_next  = status_res(ST_UNKNOWN, code);
                  state_next = S_EMIT;
                end
              end
            end
          end
        end
      end
      S_EMIT: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      S_LEN: begin
        if (too_long) begin
          pend_next  = status_res(ST_BAD_LEN, FC_WRITE);
          state_next = S_EMIT;
        end else begin
          n_last_next  = 6'(n_full - 9'd1);
          idx_next     = '0;
          crc_chk_next = CRC_INIT;
          state_next   = S_CRC;
        end
      end
      S_CRC: begin
        crc_chk_next = crc_run;
        idx_next     = idx + 6'd1;
        if (idx == n_last) begin
          state_next = S_CKLO;
        end
      end
      S_CKLO: begin
        lo_ok_next = (ram_rdata == crc_chk[7:0]);
        idx_next   = idx + 6'd1;
        state_next = S_CKHI;
      end
      S_CKHI: begin
        if (!(lo_ok && (ram_rdata == crc_chk[15:8]))) begin
          pend_next  = status_res(ST_CRC_ERR, FC_WRITE);
          state_next = S_EMIT;
        end else if (frame_len == LEN_MIN_L) begin
          pend_next  = status_res(ST_WRITE_OK, FC_WRITE);
          state_next = S_EMIT;
        end else begin
          idx_next   = 6'(PAYLOAD_START);
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        pend_next.status        = ST_WRITE_OK;
        pend_next.function_code = FC_WRITE;
        pend_next.data_index    = idx;
        pend_next.data_byte     = ram_rdata;
        pend_next.last          = ((idx_ext + 7'd3) == frame_len);
        state_next              = S_RUNEMIT;
      end
      S_RUNEMIT: begin
        if (res_ready) begin
          if (pend.last) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + 6'd1;
            state_next = S_RUN;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (end_now) begin
      receiving_next = 1'b0;
      pos_next       = '0;
      gap_next       = '0;
      crc_next       = CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      receiving <= 1'b0;
      pos       <= '0;
      gap       <= '0;
      crc       <= CRC_INIT;
    end else begin
      state     <= state_next;
      receiving <= receiving_next;
      pos       <= pos_next;
      gap       <= gap_next;
      crc       <= crc_next;
    end
  end

  always_ff @(posedge clk) begin
    fc      <= fc_next;
    idx     <= idx_next;
    n_last  <= n_last_next;
    crc_chk <= crc_chk_next;
    lo_ok   <= lo_ok_next;
    pend    <= pend_next;
  end

  `ASSERT_IMPLY(a_recv_pos, clk, rst, receiving, (pos != '0) && (pos < frame_len))
  `ASSERT_IMPLY(a_res_not_recv, clk, rst, res_valid, !receiving)
  `ASSERT_IMPLY(a_crc_idx, clk, rst, state == S_CRC, idx <= n_last)
  `ASSERT_IMPLY(a_run_idx, clk, rst, state == S_RUNEMIT, (idx >= 6'(PAYLOAD_START)) && ((idx_ext + 7'd3) <= frame_len))
  `ASSERT_NEXT(a_len_to_crc, clk, rst, (state == S_LEN) && !too_long, state == S_CRC)

endmodule
`default_nettype wire

### rtl/serial_frame_receiver_crc_check_unit.sv
// A byte or tick is taken only while idle; a status result passes the pending-result
// register, then the output register. A write frame rereads the frame store through its
// single read port: byte count, then the n = byte count + 7 frame bytes and the two CRC
// bytes, then S_RUN and S_RUNEMIT per payload result. One input per cycle while idle.
// Reset is synchronous and clears control state and configuration; the frame store
// is not cleared and needs no clearing pass.
`default_nettype none
module serial_frame_receiver_crc_check_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  input  wire logic        s_axis_tuser,   // kind[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // status[2:0], function_code[10:3],
                                           // data_index[16:11], data_byte[24:17]
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);
  import fsr_pkg::*;

  cfg_t              cfg;
  ram_wr_t           ram_wr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic              res_valid;
  logic              res_ready;
  res_t              res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slave_address     <= SLAVE_ADDR_RST;
      cfg.gap_timeout_ticks <= GAP_TICKS_RST;
      cfg.long_frame_bytes  <= LONG_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SLAVE_ADDR: cfg.slave_address     <= cfg_data[7:0];
        CFG_GAP_TICKS:  cfg.gap_timeout_ticks <= cfg_data;
        CFG_LONG_LEN:   cfg.long_frame_bytes  <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  fsr_frame_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_kind   (s_axis_tuser),
    .in_byte   (s_axis_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_wr    (ram_wr),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  fsr_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (res_valid),
    .in_ready      (res_ready),
    .in_res        (res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

### dv/tb_serial_frame_receiver_crc_check_unit.sv
// Testbench for serial_frame_receiver_crc_check_unit: directed frames, then random
// frames under several register settings, checked against an in-bench frame predictor.
// Depends on fsr_pkg and the receiver RTL.
module tb_serial_frame_receiver_crc_check_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import fsr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int MAX_REPORTS    = 10;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef enum logic [2:0] {
    ROW_BYTE, ROW_CRC_LO, ROW_CRC_HI, ROW_TICK, ROW_CFG
  } row_op_t;

  typedef struct packed {
    row_op_t    op;
    logic [1:0] idx;
    logic [9:0] val;
    logic       chk;
    status_t    st;
    logic [7:0] fc;
  } dir_row_t;

  localparam int DIR_ROWS = 29;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [9:0]  cfg_data;

  serial_frame_receiver_crc_check_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Frame predictor state and register copies
  logic [7:0]  frm_mem [FRAME_DEPTH];
  int unsigned frm_pos;
  bit          in_frame;
  logic [9:0]  gap_cnt;
  logic [15:0] crc_run;
  logic [7:0]  reg_addr;
  logic [9:0]  reg_gap;
  logic [6:0]  reg_len;

  res_t due_q [$];
  bit   typed_on;
  res_t typed_res;

  int send_idle_pct;
  int recv_stall_pct;
  int errs;
  int stall_run;

  res_t        got;
  res_t        want;
  dir_row_t    dir_rows [DIR_ROWS];
  dir_row_t    row_cur;
  logic [15:0] crc_hold;
  logic [7:0]  row_byte;

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    logic        lsb;
    v = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      lsb = v[0];
      v = {1'b0, v[15:1]};
      if (lsb) v = v ^ CRC_POLY;
    end
    return v;
  endfunction

  function automatic logic [15:0] crc_of(input logic [7:0] q [$]);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (q[j]) c = crc_step(c, q[j]);
    return c;
  endfunction

  function automatic logic [7:0] store_at(input int unsigned i);
    return (i < FRAME_DEPTH) ? frm_mem[i] : 8'h00;
  endfunction

  function automatic int unsigned frame_bytes();
    int unsigned l;
    l = reg_len;
    if (l < 9) l = 9;
    if (l > LEN_MAX) l = LEN_MAX;
    return l;
  endfunction

  task automatic post(input status_t st, input logic [7:0] fc, input logic [5:0] ix,
                      input logic [7:0] db, input logic lst);
    res_t r;
    if (typed_on) begin
      r = typed_res;
    end else begin
      r.status        = st;
      r.function_code = fc;
      r.data_index    = ix;
      r.data_byte     = db;
      r.last          = lst;
    end
    due_q.push_back(r);
  endtask

  task automatic close_frame();
    in_frame = 1'b0;
    frm_pos  = 0;
    gap_cnt  = '0;
    crc_run  = CRC_INIT;
  endtask

  task automatic close_write(input int unsigned len);
    int unsigned n;
    logic [15:0] c;
    n = store_at(BYTE_COUNT_POS) + PAYLOAD_START;
    if (n + 2 > len) begin
      post(ST_BAD_LEN, FC_WRITE, 6'd0, 8'h00, 1'b1);
    end else begin
      c = CRC_INIT;
      for (int unsigned i = 0; i < n; i++) c = crc_step(c, store_at(i));
      if (c[7:0] != store_at(n) || c[15:8] != store_at(n + 1)) begin
        post(ST_CRC_ERR, FC_WRITE, 6'd0, 8'h00, 1'b1);
      end else if (len < 10) begin
        post(ST_WRITE_OK, FC_WRITE, 6'd0, 8'h00, 1'b1);
      end else begin
        for (int unsigned i = PAYLOAD_START; i + 3 <= len; i++)
          post(ST_WRITE_OK, FC_WRITE, 6'(i), store_at(i), (i + 3 == len));
      end
    end
  endtask

  task automatic predict_item(input logic k, input logic [7:0] b);
    int unsigned len;
    int unsigned lim;
    logic [7:0]  code;
    len = frame_bytes();
    if (k == KIND_TICK) begin
      lim = (reg_gap == 0) ? 1 : reg_gap;
      if (!in_frame) return;
      if (gap_cnt != 10'h3FF) gap_cnt++;
      if (gap_cnt < lim) return;
      code = (frm_pos >= 2) ? store_at(1) : 8'h00;
      close_frame();
      post(ST_TIMEOUT, code, 6'd0, 8'h00, 1'b1);
      return;
    end
    gap_cnt = '0;
    if (!in_frame) begin
      if (b == reg_addr) begin
        in_frame   = 1'b1;
        frm_mem[0] = b;
        frm_pos    = 1;
        crc_run    = crc_step(CRC_INIT, b);
      end
      return;
    end
    if (frm_pos < FRAME_DEPTH) frm_mem[frm_pos] = b;
    frm_pos++;
    crc_run = crc_step(crc_run, b);
    code = store_at(1);
    if (code == FC_QUERY) begin
      if (frm_pos < QUERY_LEN) return;
      post((crc_run == 16'h0000) ? ST_QUERY_OK : ST_CRC_ERR, code, 6'd0, 8'h00, 1'b1);
      close_frame();
      return;
    end
    if (code == FC_TEST) begin
      post(ST_TEST, code, 6'd0, 8'h00, 1'b1);
      close_frame();
      return;
    end
    if (frm_pos < len) return;
    if (code == FC_WRITE) close_write(len);
    else post(ST_UNKNOWN, code, 6'd0, 8'h00, 1'b1);
    close_frame();
  endtask

  task automatic push_item(input logic k, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_item(k, b);
  endtask

  task automatic write_reg(input logic [1:0] i, input logic [9:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= i;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (i)
      CFG_SLAVE_ADDR: reg_addr = d[7:0];
      CFG_GAP_TICKS:  reg_gap  = d;
      CFG_LONG_LEN:   reg_len  = d[6:0];
      default: ;
    endcase
  endtask

  // Abort any open frame, drain results, then let the pipeline empty.
  task automatic settle();
    while (in_frame) push_item(KIND_TICK, 8'($urandom));
    s_axis_tvalid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_noise();
    logic [7:0] b;
    case ($urandom_range(3))
      0: begin
        b = 8'($urandom);
        if (b == reg_addr) b = b ^ 8'h01;
        push_item(KIND_BYTE, b);
      end
      1: push_item(KIND_TICK, 8'($urandom));
      default: ;
    endcase
  endtask

  task automatic send_frame();
    logic [7:0]  fb [$];
    logic [15:0] c;
    logic [7:0]  code;
    int unsigned pick, len, bc, n, lim, cut, pos;
    bit          timeout_tail;
    len = frame_bytes();
    lim = (reg_gap == 0) ? 1 : reg_gap;
    pick = $urandom_range(99);
    timeout_tail = 1'b0;
    fb.push_back(reg_addr);
    if (pick < 30) begin
      fb.push_back(FC_QUERY);
      repeat (4) fb.push_back(8'($urandom));
      c = crc_of(fb);
      fb.push_back(c[7:0]);
      fb.push_back(c[15:8]);
      if (pick >= 20) begin
        pos = $urandom_range(7, 2);
        fb[pos] = fb[pos] ^ (8'h01 << $urandom_range(7));
      end
    end else if (pick < 60) begin
      fb.push_back(FC_WRITE);
      repeat (4) fb.push_back(8'($urandom));
      if (pick < 54) bc = $urandom_range(len - 9, 0);
      else bc = $urandom_range(255, len - 8);
      fb.push_back(8'(bc));
      n = bc + PAYLOAD_START;
      if (n + 2 <= len) begin
        while (fb.size() < n) fb.push_back(8'($urandom));
        c = crc_of(fb);
        fb.push_back(c[7:0]);
        fb.push_back(c[15:8]);
        if (pick >= 48) begin
          pos = $urandom_range(n + 1, PAYLOAD_START);
          fb[pos] = fb[pos] ^ (8'h01 << $urandom_range(7));
        end
      end
      while (fb.size() < len) fb.push_back(8'($urandom));
    end else if (pick < 70 || (pick >= 80 && lim > 50)) begin
      fb.push_back(FC_TEST);
    end else if (pick < 80) begin
      code = 8'($urandom);
      while (code == FC_QUERY || code == FC_WRITE || code == FC_TEST) code = 8'($urandom);
      fb.push_back(code);
      while (fb.size() < len) fb.push_back(8'($urandom));
    end else begin
      cut = $urandom_range(5);
      for (int unsigned i = 0; i < cut; i++) begin
        code = 8'($urandom);
        if (i == 0 && code == FC_TEST) code = 8'hAC;
        fb.push_back(code);
      end
      timeout_tail = 1'b1;
    end
    for (int i = 0; i < fb.size(); i++) begin
      push_item(KIND_BYTE, fb[i]);
      if (i + 1 < fb.size()) begin
        if (lim > 1 && $urandom_range(99) < 10)
          repeat ($urandom_range((lim - 1 > 3) ? 3 : lim - 1, 1))
            push_item(KIND_TICK, 8'($urandom));
        else if (lim <= 50 && $urandom_range(99) < 3)
          repeat (lim) push_item(KIND_TICK, 8'($urandom));
      end
    end
    if (timeout_tail) repeat (lim) push_item(KIND_TICK, 8'($urandom));
  endtask

  task automatic run_phase(input logic [7:0] a, input logic [9:0] g, input logic [6:0] l,
                           input int idle, input int stall, input int frames);
    settle();
    write_reg(CFG_SLAVE_ADDR, {2'($urandom_range(3)), a});
    write_reg(CFG_GAP_TICKS, g);
    write_reg(CFG_SPARE, 10'($urandom));
    write_reg(CFG_LONG_LEN, {3'($urandom_range(7)), l});
    cfg_valid <= 1'b0;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (frames) begin
      if ($urandom_range(99) < 30) send_noise();
      send_frame();
    end
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status        = status_t'(m_axis_tdata[2:0]);
      got.function_code = m_axis_tdata[10:3];
      got.data_index    = m_axis_tdata[16:11];
      got.data_byte     = m_axis_tdata[24:17];
      got.last          = m_axis_tlast;
      if (due_q.size() == 0) begin
        errs++;
        if (errs <= MAX_REPORTS)
          $display("unexpected result: st=%0d fc=%02h idx=%0d db=%02h last=%0b",
                   got.status, got.function_code, got.data_index, got.data_byte, got.last);
      end else begin
        want = due_q.pop_front();
        if (got !== want) begin
          errs++;
          if (errs <= MAX_REPORTS)
            $display("mismatch: exp st=%0d fc=%02h idx=%0d db=%02h last=%0b, got st=%0d fc=%02h idx=%0d db=%02h last=%0b",
                     want.status, want.function_code, want.data_index, want.data_byte,
                     want.last, got.status, got.function_code, got.data_index,
                     got.data_byte, got.last);
        end
      end
    end
  end

  initial begin
    stall_run = 0;
    while (stall_run < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        stall_run = 0;
      else
        stall_run++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = 8'h00;
    s_axis_tuser   = KIND_BYTE;
    m_axis_tready  = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_SLAVE_ADDR;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    errs           = 0;
    typed_on       = 1'b0;
    crc_hold       = CRC_INIT;
    foreach (frm_mem[i]) frm_mem[i] = 8'h00;
    close_frame();
    reg_addr = SLAVE_ADDR_RST;
    reg_gap  = GAP_TICKS_RST;
    reg_len  = LONG_LEN_RST;

    dir_rows = '{
      '{ROW_TICK,   CFG_SLAVE_ADDR, 10'h000, 1'b0, ST_QUERY_OK, 8'h00},
      '{ROW_BYTE,   CFG_SLAVE_ADDR, 10'h055, 1'b0, ST_QUERY_OK, 8'h00},
      '{ROW_BYTE,   CFG_SLAVE_ADDR, 10'h000, 1'b0, ST_QUERY_OK, 8'h00},
      '{ROW_BYTE,   CFG_SLAVE_ADDR, 10'h0AD, 1'b1, ST_TEST,     FC_TEST},
      '{ROW_CFG,    CFG_GAP_TICKS,  10'h000, 1'b0, ST_QUERY_OK, 8'h00},
      '{ROW_BYTE,   CFG_SLAVE_ADDR, 10'h000, 1'b0, ST_QUERY_OK, 8'h00},
      '{ROW_TICK,   CFG_SLAVE_ADDR, 10'h000, 1'b1, ST_TIMEOUT,  8'h00},
      '{ROW_BYTE,   CFG_SLAVE_ADDR, 10'h000, 1'b0, ST_QUERY_OK, 8'h00},
      '{ROW_BYTE,   CFG_SLAVE_ADDR, 10'h003, 1'b0, ST_QUERY_OK, 8'h00},
      '{ROW_TICK,   CFG_SLAVE_ADDR, 10'h3FF, 1'b1, ST_TIMEOUT,  FC_QUERY},
      '{ROW_CFG,    CFG_SLAVE_ADDR, 10'h0FF, 1'b0, ST_QUERY_OK, 8'h00},
      '{ROW_BYTE,   CFG_SLAVE_ADDR, 10'h0FF, 1'b0, ST_QUERY_OK, 8'h00},
      '{ROW_BYTE,   CFG_SLAVE_ADDR, 10'h003, 1'b0, ST_QUERY_OK, 8'h00},
      '{ROW_BYTE,   CFG_SLAVE_ADDR, 10'h000, 1'b0, ST_QUERY_OK, 8'h00},
      '{ROW_BYTE,   CFG_SLAVE_ADDR, 10'h000, 1'b0, ST_QUERY_OK, 8'h00},
      '{ROW_BYTE,   CFG_SLAVE_ADDR, 10'h000, 1'b0, ST_QUERY_OK, 8'h00},
      '{ROW_BYTE,   CFG_SLAVE_ADDR, 10'h001, 1'b0, ST_QUERY_OK, 8'h00},
      '{ROW_CRC_LO, CFG_SLAVE_ADDR, 10'h000, 1'b0, ST_QUERY_OK, 8'h00},
      '{ROW_CRC_HI, CFG_SLAVE_ADDR, 10'h000, 1'b1, ST_QUERY_OK, FC_QUERY},
      '{ROW_CFG,    CFG_LONG_LEN,   10'h000, 1'b0, ST_QUERY_OK, 8'h00},
      '{ROW_BYTE,   CFG_SLAVE_ADDR, 10'h0FF, 1'b0, ST_QUERY_OK, 8'h00},
      '{ROW_BYTE,   CFG_SLAVE_ADDR, 10'h010, 1'b0, ST_QUERY_OK, 8'h00},
      '{ROW_BYTE,   CFG_SLAVE_ADDR, 10'h000, 1'b0, ST_QUERY_OK, 8'h00},
      '{ROW_BYTE,   CFG_SLAVE_ADDR, 10'h000, 1'b0, ST_QUERY_OK, 8'h00},
      '{ROW_BYTE,   CFG_SLAVE_ADDR, 10'h000, 1'b0, ST_QUERY_OK, 8'h00},
      '{ROW_BYTE,   CFG_SLAVE_ADDR, 10'h000, 1'b0, ST_QUERY_OK, 8'h00},
      '{ROW_BYTE,   CFG_SLAVE_ADDR, 10'h000, 1'b0, ST_QUERY_OK, 8'h00},
      '{ROW_CRC_LO, CFG_SLAVE_ADDR, 10'h000, 1'b0, ST_QUERY_OK, 8'h00},
      '{ROW_CRC_HI, CFG_SLAVE_ADDR, 10'h000, 1'b1, ST_WRITE_OK, FC_WRITE}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      row_cur = dir_rows[r];
      if (row_cur.op == ROW_CFG) begin
        settle();
        write_reg(row_cur.idx, row_cur.val);
        cfg_valid <= 1'b0;
      end else begin
        case (row_cur.op)
          ROW_CRC_LO: begin
            crc_hold = crc_run;
            row_byte = crc_hold[7:0];
          end
          ROW_CRC_HI: row_byte = crc_hold[15:8];
          default:    row_byte = row_cur.val[7:0];
        endcase
        typed_on  = row_cur.chk;
        typed_res = '{row_cur.st, row_cur.fc, 6'd0, 8'h00, 1'b1};
        push_item((row_cur.op == ROW_TICK) ? KIND_TICK : KIND_BYTE, row_byte);
        typed_on  = 1'b0;
      end
    end

    run_phase(8'($urandom), 10'($urandom_range(6, 2)), 7'($urandom_range(16, 9)), 0, 0, 5);
    run_phase(8'h00, 10'd1, 7'd9, 45, 0, 5);
    run_phase(8'hFF, 10'd1023, 7'd127, 0, 45, 2);
    run_phase(8'($urandom), 10'd0, 7'd10, 23, 23, 5);
    run_phase(8'($urandom), 10'($urandom_range(8, 1)), 7'($urandom_range(24, 9)), 23, 23, 5);
    settle();

    if (errs == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
